@@ rtl/sccb_register_master_core_defines.svh @@
// ----------------------------------------------------------------------------
// SCCB register master: assertion macros
// Concurrent assertion helpers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SCCB_REGISTER_MASTER_CORE_DEFINES_SVH
`define SCCB_REGISTER_MASTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, checked on every clock edge outside reset
`define SCCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication
`define SCCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SCCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCCB_ASSERT(lbl, prop, msg)
`define SCCB_ASSERT_IMP(lbl, ante, cons, msg)
`define SCCB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/sccb_rm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register master package
// Shared widths, register indexes, reset values and interface structs.
// ----------------------------------------------------------------------------
package sccb_rm_pkg;

  // Field widths
  localparam int DEV_ADDR_W  = 7;
  localparam int TICKS_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Default width of the phase/gap tick counter
  localparam int TICK_CNT_W_DEFAULT = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS      = 2'd2;

  // Configuration reset values
  localparam logic [DEV_ADDR_W-1:0] DEVICE_ADDRESS_RST = 7'd48;
  localparam logic [TICKS_W-1:0]    PHASE_TICKS_RST    = 16'd100;
  localparam logic [TICKS_W-1:0]    GAP_TICKS_RST      = 16'd1000;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [DEV_ADDR_W-1:0] device_address;
    logic [TICKS_W-1:0]    phase_ticks;
    logic [TICKS_W-1:0]    gap_ticks;
  } cfg_t;

  // One tick worth of pin levels and status
  typedef struct packed {
    logic              scl;
    logic              sda_out;
    logic              sda_drive;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] read_data;
  } result_t;

endpackage

@@ rtl/sccb_rm_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register master configuration registers
// Holds device address, phase length and gap length; written by index.
// ----------------------------------------------------------------------------
module sccb_rm_cfg
  import sccb_rm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= DEVICE_ADDRESS_RST;
      cfg_q.phase_ticks    <= PHASE_TICKS_RST;
      cfg_q.gap_ticks      <= GAP_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data_i[DEV_ADDR_W-1:0];
        CFG_PHASE_TICKS:    cfg_q.phase_ticks    <= cfg_data_i[TICKS_W-1:0];
        CFG_GAP_TICKS:      cfg_q.gap_ticks      <= cfg_data_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/sccb_rm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register master phase sequencer
// Advances the bus waveform by one tick per step and reports pin levels.
// ----------------------------------------------------------------------------
module sccb_rm_seq
  import sccb_rm_pkg::*;
#(
  parameter int TickCntWidth = TICK_CNT_W_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              step_i,
  input  logic              request_i,
  input  logic              opcode_i,
  input  logic [BYTE_W-1:0] register_address_i,
  input  logic [BYTE_W-1:0] write_data_i,
  input  logic              sda_in_i,
  output result_t           res_o
);

  localparam int LimW = (TickCntWidth > TICKS_W) ? TickCntWidth : TICKS_W;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START_A  = 5'd1,
    PH_START_B  = 5'd2,
    PH_START_C  = 5'd3,
    PH_BIT_SET  = 5'd4,
    PH_BIT_HIGH = 5'd5,
    PH_BIT_LOW  = 5'd6,
    PH_BIT_CLR  = 5'd7,
    PH_ACK_SET  = 5'd8,
    PH_ACK_HIGH = 5'd9,
    PH_ACK_LOW  = 5'd10,
    PH_RD_HIGH  = 5'd11,
    PH_RD_LOW   = 5'd12,
    PH_STOP_A   = 5'd13,
    PH_STOP_B   = 5'd14,
    PH_STOP_C   = 5'd15,
    PH_GAP      = 5'd16
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [1:0]              byte_q, byte_d;
  logic [3:0]              bit_q, bit_d;
  logic [BYTE_W-1:0]       shift_q, shift_d;
  logic [TickCntWidth-1:0] tick_q, tick_d;
  logic                    op_q, op_d;
  logic [BYTE_W-1:0]       addr_q, addr_d;
  logic [BYTE_W-1:0]       data_q, data_d;
  logic [BYTE_W-1:0]       recv_q, recv_d;

  phase_e                  ph_cur;
  logic [LimW-1:0]         lim_raw;
  logic [LimW-1:0]         cnt_max;
  logic [TickCntWidth-1:0] limit;
  logic [TickCntWidth-1:0] tick_n;
  logic [3:0]              bit_n;
  logic [1:0]              byte_n;
  logic                    done;
  logic                    shift_msb;

  // Data bit on SDA comes from the byte as it stands before this tick's advance
  assign shift_msb = (phase_q == PH_IDLE && request_i) ? 1'b0 : shift_q[BYTE_W-1];

  // Next-state and pin levels for one tick
  always_comb begin
    phase_d = phase_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tick_d  = tick_q;
    op_d    = op_q;
    addr_d  = addr_q;
    data_d  = data_q;
    recv_d  = recv_q;
    done    = 1'b0;
    bit_n   = bit_q + 4'd1;
    byte_n  = byte_q + 2'd1;

    // Idle request: capture and start the same tick
    if (phase_q == PH_IDLE && request_i) begin
      op_d    = opcode_i;
      addr_d  = register_address_i;
      data_d  = write_data_i;
      byte_d  = '0;
      bit_d   = '0;
      shift_d = '0;
      tick_d  = '0;
      phase_d = PH_START_A;
    end
    ph_cur = phase_d;

    // Phase length: zero acts as one, clipped to the counter range
    cnt_max = LimW'({TickCntWidth{1'b1}});
    lim_raw = (ph_cur == PH_GAP) ? LimW'(cfg_i.gap_ticks) : LimW'(cfg_i.phase_ticks);
    if (lim_raw == '0) lim_raw = LimW'(1);
    if (lim_raw > cnt_max) lim_raw = cnt_max;
    limit  = lim_raw[TickCntWidth-1:0];
    tick_n = tick_d + TickCntWidth'(1);

    if (ph_cur != PH_IDLE) begin
      if (tick_n >= limit) begin
        tick_d = '0;
        unique case (ph_cur)
          PH_GAP: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          PH_START_A: phase_d = PH_START_B;
          PH_START_B: phase_d = PH_START_C;
          PH_START_C: begin
            shift_d = {cfg_i.device_address, (op_d && byte_d == 2'd2)};
            bit_d   = '0;
            phase_d = PH_BIT_SET;
          end
          PH_BIT_SET:  phase_d = PH_BIT_HIGH;
          PH_BIT_HIGH: phase_d = PH_BIT_LOW;
          PH_BIT_LOW:  phase_d = PH_BIT_CLR;
          PH_BIT_CLR: begin
            shift_d = {shift_d[BYTE_W-2:0], 1'b0};
            if (bit_n[3]) begin
              bit_d   = '0;
              phase_d = PH_ACK_SET;
            end else begin
              bit_d   = bit_n;
              phase_d = PH_BIT_SET;
            end
          end
          PH_ACK_SET:  phase_d = PH_ACK_HIGH;
          PH_ACK_HIGH: phase_d = PH_ACK_LOW;
          PH_ACK_LOW: begin
            if (op_d && byte_d == 2'd3) begin
              // NACK after the read byte
              phase_d = PH_STOP_A;
            end else begin
              byte_d = byte_n;
              if (byte_n == 2'd1) begin
                shift_d = addr_d;
                phase_d = PH_BIT_SET;
              end else if (!op_d && byte_n == 2'd2) begin
                shift_d = data_d;
                phase_d = PH_BIT_SET;
              end else if (!op_d || byte_n == 2'd2) begin
                phase_d = PH_STOP_A;
              end else begin
                shift_d = '0;
                bit_d   = '0;
                phase_d = PH_RD_HIGH;
              end
            end
          end
          PH_RD_HIGH: begin
            shift_d = {shift_d[BYTE_W-2:0], sda_in_i};
            phase_d = PH_RD_LOW;
          end
          PH_RD_LOW: begin
            if (bit_n[3]) begin
              bit_d   = '0;
              recv_d  = shift_d;
              phase_d = PH_ACK_SET;
            end else begin
              bit_d   = bit_n;
              phase_d = PH_RD_HIGH;
            end
          end
          PH_STOP_A: phase_d = PH_STOP_B;
          PH_STOP_B: phase_d = PH_STOP_C;
          PH_STOP_C: begin
            if (op_d && byte_d == 2'd2) begin
              // restart for the read half
              phase_d = PH_START_A;
            end else if (cfg_i.gap_ticks == '0) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              phase_d = PH_GAP;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end else begin
        tick_d = tick_n;
      end
    end
  end

  // Pin levels of the phase shown this tick
  always_comb begin
    res_o.scl       = 1'b1;
    res_o.sda_out   = 1'b1;
    res_o.sda_drive = 1'b1;
    unique case (ph_cur)
      PH_START_B: res_o.sda_out = 1'b0;
      PH_START_C, PH_BIT_CLR, PH_STOP_A: begin
        res_o.scl     = 1'b0;
        res_o.sda_out = 1'b0;
      end
      PH_BIT_SET, PH_BIT_LOW: begin
        res_o.scl     = 1'b0;
        res_o.sda_out = shift_msb;
      end
      PH_BIT_HIGH: res_o.sda_out = shift_msb;
      PH_ACK_SET, PH_ACK_LOW: res_o.scl = 1'b0;
      PH_RD_HIGH: res_o.sda_drive = 1'b0;
      PH_RD_LOW: begin
        res_o.scl       = 1'b0;
        res_o.sda_drive = 1'b0;
      end
      PH_STOP_B: res_o.sda_out = 1'b0;
      default: ;
    endcase
    res_o.busy      = (ph_cur != PH_IDLE);
    res_o.done      = done;
    res_o.read_data = recv_q;
  end

  // Sequencer state, updated once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      byte_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      tick_q  <= '0;
      op_q    <= 1'b0;
      addr_q  <= '0;
      data_q  <= '0;
      recv_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tick_q  <= tick_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
      recv_q  <= recv_d;
    end
  end

endmodule

@@ rtl/sccb_register_master_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register master core
// Tick-driven SCCB master: one input transfer per tick, one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Every input transfer (in_valid_i/in_ready_o) is one tick of bus time and
//   carries request, opcode, register address, write data and the sampled SDA
//   level. Every tick returns exactly one result transfer (out_valid_o /
//   out_ready_i) with SCL, SDA, SDA drive enable, busy, done and read data.
//   A request is taken only while idle; requests seen while busy are ignored.
//   An input transfer passes through the input register, then through the
//   sequencer into the result register. Throughput is one tick per cycle
//   while the receiver takes each result, set by the phase sequencer step;
//   a new tick is taken while the previous result waits.
//   When the receiver stalls, the result register holds and the input
//   register fills, after which in_ready_o drops until the result is taken.
//   The configuration channel (cfg_valid_i/cfg_ready_o) is always ready and
//   writes device address, phase ticks or gap ticks by index.
//   Reset puts the sequencer idle, where it shows SCL and SDA high and driven,
//   clears its read data and loads the configuration defaults.
// ----------------------------------------------------------------------------
`include "sccb_register_master_core_defines.svh"

module sccb_register_master_core
  import sccb_rm_pkg::*;
#(
  parameter int TickCntWidth = TICK_CNT_W_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // tick input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  request_i,
  input  logic                  opcode_i,
  input  logic [BYTE_W-1:0]     register_address_i,
  input  logic [BYTE_W-1:0]     write_data_i,
  input  logic                  sda_in_i,
  // tick result
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  scl_o,
  output logic                  sda_out_o,
  output logic                  sda_drive_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic [BYTE_W-1:0]     read_data_o
);

  cfg_t              cfg;
  result_t           res;
  result_t           out_q;
  logic              out_valid_q;
  logic              in_valid_q;
  logic              req_q;
  logic              op_q;
  logic [BYTE_W-1:0] addr_q;
  logic [BYTE_W-1:0] data_q;
  logic              sda_q;
  logic              step;

  sccb_rm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline control: step when a tick is held and the result slot frees
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q  <= request_i;
      op_q   <= opcode_i;
      addr_q <= register_address_i;
      data_q <= write_data_i;
      sda_q  <= sda_in_i;
    end
  end

  sccb_rm_seq #(
    .TickCntWidth (TickCntWidth)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .step_i             (step),
    .request_i          (req_q),
    .opcode_i           (op_q),
    .register_address_i (addr_q),
    .write_data_i       (data_q),
    .sda_in_i           (sda_q),
    .res_o              (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = out_q.scl;
  assign sda_out_o   = out_q.sda_out;
  assign sda_drive_o = out_q.sda_drive;
  assign busy_res_o  = out_q.busy;
  assign done_res_o  = out_q.done;
  assign read_data_o = out_q.read_data;

  // Checks
  `SCCB_ASSERT_NXT(a_step_fills_out, step, out_valid_q, "stepped tick produced no result")
  `SCCB_ASSERT_IMP(a_stall_cause, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i,
                   "input stalled without a blocked result")
  `SCCB_ASSERT_IMP(a_done_busy, out_valid_q && out_q.done, out_q.busy,
                   "done raised on an idle tick")
  `SCCB_ASSERT_IMP(a_release_high, out_valid_q && !out_q.sda_drive, out_q.sda_out,
                   "released SDA not held high")

endmodule
